@@ rtl/byte_stream_tokenizer_defines.svh @@
// Assertion macros for the byte stream tokenizer RTL.
// Included by the top level; depends on nothing else.
`ifndef BYTE_STREAM_TOKENIZER_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_DEFINES_SVH

`ifndef SYNTH
// Concurrent implication checked in the same cycle, off while in reset.
`define BST_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Concurrent invariant, off while in reset.
`define BST_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");
`else
`define BST_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define BST_ASSERT_ALWAYS(label, clk, rstn, expr)
`endif

`endif

@@ rtl/bst_pkg.sv @@
// Types, character codes and helper functions for the byte stream tokenizer.
// No dependencies.
`default_nettype none

package bst_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [15:0] MAX16 = 16'hFFFF;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    typedef enum logic [3:0] {
        KIND_EOF     = 4'd0,
        KIND_NEWLINE = 4'd1,
        KIND_IDENT   = 4'd2,
        KIND_NUMBER  = 4'd3,
        KIND_STRING  = 4'd4,
        KIND_LPAREN  = 4'd5,
        KIND_RPAREN  = 4'd6,
        KIND_COMMA   = 4'd7,
        KIND_EQUAL   = 4'd8,
        KIND_UNKNOWN = 4'd9
    } kind_t;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_IDENT  = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_STRING = 4'b1000
    } mode_t;

    typedef struct packed {
        logic        last;
        logic [15:0] error_total;
        logic [15:0] token_total;
        logic [15:0] line_number;
        logic [15:0] token_length;
        logic [15:0] start_offset;
        kind_t       token_kind;
    } result_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == MAX16) ? v : v + 16'd1;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc_cnt(input logic [COUNT_WIDTH-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // Shows a counter on a 16-bit field, clamped at the field's maximum.
    function automatic logic [15:0] show16(input logic [COUNT_WIDTH-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'(MAX16)) ? MAX16 : w[15:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/byte_stream_tokenizer.sv @@
// Byte stream tokenizer top level: scanner logic and a small result queue.
// Depends on bst_pkg and byte_stream_tokenizer_defines.svh.
// A byte is held in the input register, then its tokens are written to the result queue.
// Throughput: one byte per cycle while each byte yields at most one token and the
// result side takes tokens; a byte that closes a pending token and makes one of its
// own takes two queue slots, and the 4-entry result queue drains one token per cycle.
// Reset: aresetn is synchronous, active low; it empties the queue and returns the
// scanner to idle at offset 0, line 1, with both counters at zero.
`default_nettype none
`include "byte_stream_tokenizer_defines.svh"

module byte_stream_tokenizer (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] ch
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [3:0] token_kind, [19:4] start_offset, [35:20] token_length,
    // [51:36] line_number, [67:52] token_total, [83:68] error_total, rest zero
    output logic [87:0]       m_axis_tdata,
    output logic              m_axis_tlast    // last token caused by this byte
);

    // Input register: holds one byte until the queue has room for its tokens.
    logic [7:0] byte_reg;
    logic       byte_valid_reg;

    // Scanner state.
    bst_pkg::mode_t                      mode_reg, mode_next;
    logic [15:0]                         pos_reg, pos_next;
    logic [15:0]                         start_reg, start_next;
    logic [15:0]                         line_reg, line_next;
    logic [bst_pkg::COUNT_WIDTH-1:0]     tok_cnt_reg, tok_cnt_next;
    logic [bst_pkg::COUNT_WIDTH-1:0]     err_cnt_reg, err_cnt_next;

    // Result queue.
    bst_pkg::result_t                    queue_reg [bst_pkg::QUEUE_DEPTH];
    logic [bst_pkg::QPTR_W-1:0]          wr_ptr_reg, rd_ptr_reg;
    logic [bst_pkg::QCNT_W-1:0]          count_reg;

    logic consume;
    logic pop;

    // Scanner results for the byte in the input register: a closing token for the
    // pending identifier, number or string, and a token of the byte itself.
    logic              close_valid;
    logic              own_valid;
    logic              own_eof;
    logic              continues;
    bst_pkg::result_t  close_res;
    bst_pkg::result_t  own_res;

    logic [7:0]                      c;
    logic [15:0]                     diff;
    logic [16:0]                     str_len;
    logic [bst_pkg::COUNT_WIDTH-1:0] tok_after_close;
    logic [bst_pkg::COUNT_WIDTH-1:0] tok_after_own;
    logic [bst_pkg::COUNT_WIDTH-1:0] err_after_own;
    logic                            is_space;
    logic                            starts_token;
    bst_pkg::kind_t                  close_kind;
    bst_pkg::kind_t                  own_kind;

    // The byte moves into the queue only when two slots are free, so the queue
    // never has to take back a token once the scanner state has moved on.
    assign consume = byte_valid_reg && (count_reg <= bst_pkg::QCNT_W'(bst_pkg::QUEUE_DEPTH - 2));
    assign s_axis_tready = !byte_valid_reg || consume;
    assign pop = m_axis_tvalid && m_axis_tready;

    always_comb begin
        c        = byte_reg;
        diff     = pos_reg - start_reg;
        str_len  = {1'b0, diff} + 17'd1;
        is_space = (c == bst_pkg::CH_SPACE) || (c == bst_pkg::CH_TAB) || (c == bst_pkg::CH_CR);

        // Does the byte extend the pending token, and does it close it?
        close_valid = 1'b0;
        continues   = 1'b0;
        close_kind  = bst_pkg::KIND_IDENT;
        case (mode_reg)
            bst_pkg::MODE_IDENT: begin
                continues   = bst_pkg::is_letter(c) || bst_pkg::is_digit(c);
                close_valid = !continues;
                close_kind  = bst_pkg::KIND_IDENT;
            end
            bst_pkg::MODE_NUMBER: begin
                continues   = bst_pkg::is_digit(c);
                close_valid = !continues;
                close_kind  = bst_pkg::KIND_NUMBER;
            end
            bst_pkg::MODE_STRING: begin
                // Inside a string everything but the end byte is consumed; the
                // closing quote is part of the token.
                continues   = (c != bst_pkg::CH_NUL);
                close_valid = (c == bst_pkg::CH_QUOTE) || (c == bst_pkg::CH_NUL);
                close_kind  = bst_pkg::KIND_STRING;
            end
            default: begin
                continues   = 1'b0;
                close_valid = 1'b0;
            end
        endcase

        tok_after_close = close_valid ? bst_pkg::sat_inc_cnt(tok_cnt_reg) : tok_cnt_reg;

        close_res.token_kind   = close_kind;
        close_res.start_offset = start_reg;
        if (mode_reg == bst_pkg::MODE_STRING && c == bst_pkg::CH_QUOTE) begin
            close_res.token_length = str_len[16] ? bst_pkg::MAX16 : str_len[15:0];
        end else begin
            close_res.token_length = diff;
        end
        close_res.line_number = line_reg;
        close_res.token_total = bst_pkg::show16(tok_after_close);
        close_res.error_total = bst_pkg::show16(err_cnt_reg);
        close_res.last        = 1'b0;

        // The byte's own token, when it is not absorbed by a pending one.
        starts_token = bst_pkg::is_letter(c) || bst_pkg::is_digit(c) || (c == bst_pkg::CH_QUOTE);
        own_eof      = !continues && (c == bst_pkg::CH_NUL);
        own_valid    = !continues && !is_space && !starts_token;
        if (c == bst_pkg::CH_NUL) begin
            own_kind = bst_pkg::KIND_EOF;
        end else if (c == bst_pkg::CH_LF) begin
            own_kind = bst_pkg::KIND_NEWLINE;
        end else if (c == bst_pkg::CH_LPAREN) begin
            own_kind = bst_pkg::KIND_LPAREN;
        end else if (c == bst_pkg::CH_RPAREN) begin
            own_kind = bst_pkg::KIND_RPAREN;
        end else if (c == bst_pkg::CH_COMMA) begin
            own_kind = bst_pkg::KIND_COMMA;
        end else if (c == bst_pkg::CH_EQUAL) begin
            own_kind = bst_pkg::KIND_EQUAL;
        end else begin
            own_kind = bst_pkg::KIND_UNKNOWN;
        end

        // The end-of-source token is not counted.
        tok_after_own = (own_eof) ? tok_after_close : bst_pkg::sat_inc_cnt(tok_after_close);
        err_after_own = (own_kind == bst_pkg::KIND_UNKNOWN) ?
                        bst_pkg::sat_inc_cnt(err_cnt_reg) : err_cnt_reg;

        own_res.token_kind   = own_kind;
        own_res.start_offset = pos_reg;
        own_res.token_length = own_eof ? 16'd0 : 16'd1;
        own_res.line_number  = line_reg;
        own_res.token_total  = bst_pkg::show16(tok_after_own);
        own_res.error_total  = bst_pkg::show16(err_after_own);
        own_res.last         = 1'b1;

        close_res.last = !own_valid;

        // Next scanner state.
        mode_next    = mode_reg;
        start_next   = start_reg;
        line_next    = line_reg;
        pos_next     = bst_pkg::sat_inc16(pos_reg);
        tok_cnt_next = own_valid ? tok_after_own : tok_after_close;
        err_cnt_next = own_valid ? err_after_own : err_cnt_reg;

        if (close_valid) begin
            mode_next = bst_pkg::MODE_IDLE;
        end
        if (mode_reg == bst_pkg::MODE_STRING && continues && c == bst_pkg::CH_LF) begin
            line_next = bst_pkg::sat_inc16(line_reg);
        end
        if (!continues) begin
            if (c == bst_pkg::CH_LF) begin
                line_next = bst_pkg::sat_inc16(line_reg);
            end else if (bst_pkg::is_letter(c)) begin
                mode_next  = bst_pkg::MODE_IDENT;
                start_next = pos_reg;
            end else if (bst_pkg::is_digit(c)) begin
                mode_next  = bst_pkg::MODE_NUMBER;
                start_next = pos_reg;
            end else if (c == bst_pkg::CH_QUOTE) begin
                mode_next  = bst_pkg::MODE_STRING;
                start_next = pos_reg;
            end
        end

        // End of source: every scanner register returns to its reset value.
        if (own_eof) begin
            mode_next    = bst_pkg::MODE_IDLE;
            start_next   = 16'd0;
            line_next    = 16'd1;
            pos_next     = 16'd0;
            tok_cnt_next = '0;
            err_cnt_next = '0;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            byte_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            byte_reg <= s_axis_tdata;
        end
    end

    // Scanner state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= bst_pkg::MODE_IDLE;
            pos_reg     <= 16'd0;
            start_reg   <= 16'd0;
            line_reg    <= 16'd1;
            tok_cnt_reg <= '0;
            err_cnt_reg <= '0;
        end else if (consume) begin
            mode_reg    <= mode_next;
            pos_reg     <= pos_next;
            start_reg   <= start_next;
            line_reg    <= line_next;
            tok_cnt_reg <= tok_cnt_next;
            err_cnt_reg <= err_cnt_next;
        end
    end

    // Result queue: up to two writes and one read per cycle.
    logic [bst_pkg::QPTR_W-1:0] own_slot;
    logic [1:0]                 n_write;

    assign own_slot = wr_ptr_reg + bst_pkg::QPTR_W'(close_valid);
    assign n_write  = consume ? (2'(close_valid) + 2'(own_valid)) : 2'd0;

    always_ff @(posedge aclk) begin
        if (consume && close_valid) begin
            queue_reg[wr_ptr_reg] <= close_res;
        end
        if (consume && own_valid) begin
            queue_reg[own_slot] <= own_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + bst_pkg::QPTR_W'(n_write);
            rd_ptr_reg <= rd_ptr_reg + bst_pkg::QPTR_W'(pop);
            count_reg  <= count_reg + bst_pkg::QCNT_W'(n_write) - bst_pkg::QCNT_W'(pop);
        end
    end

    bst_pkg::result_t head;
    assign head = queue_reg[rd_ptr_reg];

    assign m_axis_tvalid = (count_reg != '0);
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {4'd0, head.error_total, head.token_total, head.line_number,
                            head.token_length, head.start_offset, head.token_kind};

    // The queue never holds more tokens than it has slots.
    `BST_ASSERT_ALWAYS(a_queue_bound, aclk, aresetn,
        count_reg <= bst_pkg::QCNT_W'(bst_pkg::QUEUE_DEPTH))
    // An end-of-source token is always the last token of its byte.
    `BST_ASSERT_IMPL(a_eof_last, aclk, aresetn,
        m_axis_tvalid && m_axis_tdata[3:0] == bst_pkg::KIND_EOF, m_axis_tlast)
    // Every real token has been counted, so its running total is never zero.
    `BST_ASSERT_IMPL(a_token_counted, aclk, aresetn,
        m_axis_tvalid && m_axis_tdata[3:0] != bst_pkg::KIND_EOF, m_axis_tdata[67:52] != 16'd0)
    // A byte is taken into the scanner only while the queue has two free slots.
    `BST_ASSERT_IMPL(a_room_on_consume, aclk, aresetn,
        consume, count_reg <= bst_pkg::QCNT_W'(bst_pkg::QUEUE_DEPTH - 2))

endmodule

`default_nettype wire

@@ verif/byte_stream_tokenizer_tb.sv @@
// Self-checking testbench for byte_stream_tokenizer: streams source text in,
// predicts every token and compares each result item field by field.
// Depends on bst_pkg and the byte_stream_tokenizer RTL.
`timescale 1ns / 1ps

module byte_stream_tokenizer_tb;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_BYTES = 1400;
    localparam int QUIET_FROM = 1200;

    // One source byte waiting to be sent, with the idling odds that apply
    // while it is at the head and a flag that makes the sender wait for all
    // outstanding tokens first.
    typedef struct packed {
        logic       drain_first;
        logic [7:0] odds;
        logic [7:0] ch;
    } src_byte_t;

    typedef struct packed {
        bst_pkg::kind_t kind;
        logic [15:0]    start;
        logic [15:0]    length;
        logic [15:0]    line;
        logic [15:0]    tokens;
        logic [15:0]    errors;
        logic           last;
    } token_t;

    logic         aclk;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata = 8'h00;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [87:0]  m_axis_tdata;
    logic         m_axis_tlast;

    byte_stream_tokenizer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    src_byte_t text_bytes[$];
    token_t    expected_tokens[$];
    int        next_item = 0;
    int        shown_item = -1;
    int        failures = 0;
    int        cycles = 0;
    int        src_gap = 0;
    int        sink_gap = 0;
    int        idle_odds = 0;
    bit        drain_next = 1'b0;
    src_byte_t head;

    // Tokenizer state as the predictor sees it.
    bst_pkg::mode_t                  scan_state;
    logic [15:0]                     byte_pos;
    logic [15:0]                     tok_start;
    logic [15:0]                     cur_line;
    logic [bst_pkg::COUNT_WIDTH-1:0] tok_count;
    logic [bst_pkg::COUNT_WIDTH-1:0] err_count;
    token_t                          step_out[0:1];
    int                              step_n;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit letter_byte(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == bst_pkg::CH_UNDER;
    endfunction

    function automatic bit digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [15:0] clamp16(input longint unsigned v);
        return (v > 64'd65535) ? bst_pkg::MAX16 : v[15:0];
    endfunction

    task automatic restart_source();
        scan_state = bst_pkg::MODE_IDLE;
        byte_pos   = 16'd0;
        tok_start  = 16'd0;
        cur_line   = 16'd1;
        tok_count  = '0;
        err_count  = '0;
    endtask

    // Records one token; the running totals include the token itself.
    task automatic add_token(input bst_pkg::kind_t k, input logic [15:0] start,
                             input int unsigned len, input logic [15:0] line);
        token_t t;
        if (k != bst_pkg::KIND_EOF) begin
            if (tok_count != '1) tok_count = tok_count + 1'b1;
            if (k == bst_pkg::KIND_UNKNOWN && err_count != '1) err_count = err_count + 1'b1;
        end
        t.kind   = k;
        t.start  = start;
        t.length = clamp16(len);
        t.line   = line;
        t.tokens = clamp16(tok_count);
        t.errors = clamp16(err_count);
        t.last   = 1'b0;
        step_out[step_n] = t;
        step_n++;
    endtask

    // Advances the predictor by one accepted byte and queues its tokens.
    task automatic scan_byte(input logic [7:0] c);
        logic [15:0]    here;
        bit             consumed;
        bit             at_end;
        bst_pkg::kind_t k;
        here     = byte_pos;
        consumed = 1'b0;
        at_end   = 1'b0;
        step_n   = 0;
        case (scan_state)
            bst_pkg::MODE_IDENT: begin
                if (letter_byte(c) || digit_byte(c)) begin
                    consumed = 1'b1;
                end else begin
                    add_token(bst_pkg::KIND_IDENT, tok_start, int'(here) - int'(tok_start),
                              cur_line);
                    scan_state = bst_pkg::MODE_IDLE;
                end
            end
            bst_pkg::MODE_NUMBER: begin
                if (digit_byte(c)) begin
                    consumed = 1'b1;
                end else begin
                    add_token(bst_pkg::KIND_NUMBER, tok_start, int'(here) - int'(tok_start),
                              cur_line);
                    scan_state = bst_pkg::MODE_IDLE;
                end
            end
            bst_pkg::MODE_STRING: begin
                if (c == bst_pkg::CH_QUOTE) begin
                    // The closing quote belongs to the string.
                    add_token(bst_pkg::KIND_STRING, tok_start,
                              int'(here) - int'(tok_start) + 1, cur_line);
                    scan_state = bst_pkg::MODE_IDLE;
                    consumed = 1'b1;
                end else if (c == bst_pkg::CH_NUL) begin
                    // Unterminated string: closed by the end of source.
                    add_token(bst_pkg::KIND_STRING, tok_start, int'(here) - int'(tok_start),
                              cur_line);
                    scan_state = bst_pkg::MODE_IDLE;
                end else begin
                    if (c == bst_pkg::CH_LF && cur_line != bst_pkg::MAX16)
                        cur_line = cur_line + 1'b1;
                    consumed = 1'b1;
                end
            end
            default: ;
        endcase

        if (!consumed) begin
            if (c == bst_pkg::CH_SPACE || c == bst_pkg::CH_TAB || c == bst_pkg::CH_CR) begin
                // Separators make no token.
            end else if (c == bst_pkg::CH_LF) begin
                add_token(bst_pkg::KIND_NEWLINE, here, 1, cur_line);
                if (cur_line != bst_pkg::MAX16) cur_line = cur_line + 1'b1;
            end else if (c == bst_pkg::CH_NUL) begin
                add_token(bst_pkg::KIND_EOF, here, 0, cur_line);
                at_end = 1'b1;
            end else if (letter_byte(c)) begin
                scan_state = bst_pkg::MODE_IDENT;
                tok_start  = here;
            end else if (digit_byte(c)) begin
                scan_state = bst_pkg::MODE_NUMBER;
                tok_start  = here;
            end else if (c == bst_pkg::CH_QUOTE) begin
                scan_state = bst_pkg::MODE_STRING;
                tok_start  = here;
            end else begin
                case (c)
                    bst_pkg::CH_LPAREN: k = bst_pkg::KIND_LPAREN;
                    bst_pkg::CH_RPAREN: k = bst_pkg::KIND_RPAREN;
                    bst_pkg::CH_COMMA:  k = bst_pkg::KIND_COMMA;
                    bst_pkg::CH_EQUAL:  k = bst_pkg::KIND_EQUAL;
                    default:            k = bst_pkg::KIND_UNKNOWN;
                endcase
                add_token(k, here, 1, cur_line);
            end
        end

        if (at_end) restart_source();
        else if (byte_pos != bst_pkg::MAX16) byte_pos = byte_pos + 1'b1;

        for (int i = 0; i < step_n; i++) begin
            if (i == step_n - 1) step_out[i].last = 1'b1;
            expected_tokens.push_back(step_out[i]);
        end
    endtask

    task automatic same_field(input string name, input longint unsigned want,
                              input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    task automatic check_token();
        token_t want;
        if (expected_tokens.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual kind %0d start %0d",
                     $time, m_axis_tdata[3:0], m_axis_tdata[19:4]);
            failures++;
            return;
        end
        want = expected_tokens.pop_front();
        same_field("token_kind", want.kind, m_axis_tdata[3:0]);
        same_field("start_offset", want.start, m_axis_tdata[19:4]);
        same_field("token_length", want.length, m_axis_tdata[35:20]);
        same_field("line_number", want.line, m_axis_tdata[51:36]);
        same_field("token_total", want.tokens, m_axis_tdata[67:52]);
        same_field("error_total", want.errors, m_axis_tdata[83:68]);
        same_field("tdata padding", 0, m_axis_tdata[87:84]);
        same_field("tlast", want.last, m_axis_tlast);
    endtask

    // Result side and input bookkeeping, both on the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t: timeout with %0d tokens outstanding", $time,
                         expected_tokens.size());
                $display("Test completed with failures");
                $finish;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                scan_byte(s_axis_tdata);
                next_item++;
            end
            if (m_axis_tvalid && m_axis_tready) check_token();
        end
    end

    // Both sides are driven on the falling edge. A presented item is held
    // until the rising-edge process has counted it as taken.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (sink_gap > 0) begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
                sink_gap = $urandom_range(5, 0);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end

            if (s_axis_tvalid && next_item == shown_item) begin
                // Still waiting for the handshake.
            end else if (next_item >= text_bytes.size()) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                head = text_bytes[next_item];
                idle_odds = head.odds;
                if (head.drain_first && expected_tokens.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (idle_odds != 0 && $urandom_range(idle_odds - 1, 0) == 0) begin
                    src_gap = $urandom_range(5, 0);
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= head.ch;
                    shown_item = next_item;
                end
            end
        end
    end

    task automatic add_byte(input logic [7:0] c, input int odds);
        src_byte_t b;
        b.ch = c;
        b.odds = odds[7:0];
        b.drain_first = drain_next;
        drain_next = 1'b0;
        text_bytes.push_back(b);
    endtask

    task automatic add_text(input string s, input int odds);
        for (int i = 0; i < s.len(); i++) add_byte(s[i], odds);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(52, 0);
        if (r < 26) return 8'("A" + r);
        if (r < 52) return 8'("a" + r - 26);
        return bst_pkg::CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(9, 0));
    endfunction

    // Any byte that the scanner turns into an unknown token from idle.
    function automatic logic [7:0] rand_unknown();
        string odd_chars;
        odd_chars = "!#$%&*+-./:;<>?@[]^{|}~";
        if ($urandom_range(3, 0) == 0) return odd_chars[$urandom_range(odd_chars.len() - 1, 0)];
        return 8'($urandom_range(255, 128));
    endfunction

    // Inner string byte: anything but the quote and the end byte.
    function automatic logic [7:0] rand_string_byte();
        logic [7:0] c;
        if ($urandom_range(3, 0) == 0) return bst_pkg::CH_LF;
        c = 8'($urandom_range(255, 1));
        return (c == bst_pkg::CH_QUOTE) ? 8'("q") : c;
    endfunction

    // One source of well-formed tokens with random content, some noise and
    // occasionally an unterminated string, closed by the end byte.
    task automatic add_random_source(input int odds);
        int n_tokens;
        int len;
        logic [7:0] punct[4];
        punct = '{bst_pkg::CH_LPAREN, bst_pkg::CH_RPAREN, bst_pkg::CH_COMMA, bst_pkg::CH_EQUAL};
        n_tokens = $urandom_range(12, 1);
        for (int t = 0; t < n_tokens; t++) begin
            case ($urandom_range(9, 0))
                0, 1: begin
                    add_byte(rand_letter(), odds);
                    len = $urandom_range(7, 0);
                    for (int i = 0; i < len; i++)
                        add_byte($urandom_range(2, 0) == 0 ? rand_digit() : rand_letter(), odds);
                end
                2: begin
                    len = $urandom_range(5, 1);
                    for (int i = 0; i < len; i++) add_byte(rand_digit(), odds);
                end
                3: begin
                    add_byte(bst_pkg::CH_QUOTE, odds);
                    len = $urandom_range(6, 0);
                    for (int i = 0; i < len; i++) add_byte(rand_string_byte(), odds);
                    add_byte(bst_pkg::CH_QUOTE, odds);
                end
                4, 5: add_byte(punct[$urandom_range(3, 0)], odds);
                6: begin
                    len = $urandom_range(3, 1);
                    for (int i = 0; i < len; i++) begin
                        case ($urandom_range(2, 0))
                            0: add_byte(bst_pkg::CH_SPACE, odds);
                            1: add_byte(bst_pkg::CH_TAB, odds);
                            default: add_byte(bst_pkg::CH_CR, odds);
                        endcase
                    end
                end
                7: add_byte(bst_pkg::CH_LF, odds);
                8: add_byte(rand_unknown(), odds);
                default: add_byte(8'($urandom_range(255, 1)), odds);
            endcase
            // Leaving out the separator makes bytes that close one token and start another.
            if ($urandom_range(1, 0) == 0) add_byte(bst_pkg::CH_SPACE, odds);
        end
        if ($urandom_range(5, 0) == 0) begin
            add_byte(bst_pkg::CH_QUOTE, odds);
            len = $urandom_range(4, 0);
            for (int i = 0; i < len; i++) add_byte(rand_string_byte(), odds);
        end
        add_byte(bst_pkg::CH_NUL, odds);
    endtask

    initial begin
        int random_start;
        int odds;
        restart_source();

        // Directed part: an empty source, every token kind, bytes that close
        // a token and start another, a string with an inner newline, high
        // bytes, an unterminated string, and a number closed by the end byte.
        add_byte(bst_pkg::CH_NUL, 3);
        add_text("_aZ9(7,q\"a\nb\" 0x=)\t\r\n", 3);
        add_byte(8'h80, 3);
        add_byte(8'hFF, 3);
        add_text("\"z", 3);
        add_byte(bst_pkg::CH_NUL, 3);
        add_text("9", 3);
        add_byte(bst_pkg::CH_NUL, 3);

        // Short source, sent once everything before it has drained: a string
        // with several inner newlines, then a run of unknown bytes.
        drain_next = 1'b1;
        add_byte(bst_pkg::CH_QUOTE, 32);
        for (int i = 0; i < 12; i++)
            add_byte((i % 4 == 3) ? rand_string_byte() : bst_pkg::CH_LF, 32);
        add_byte(bst_pkg::CH_QUOTE, 32);
        for (int i = 0; i < 20; i++) add_byte(rand_unknown(), 32);
        add_text("ab 12\n\"x\"=", 32);
        add_byte(bst_pkg::CH_NUL, 32);

        // Random part; the last stretch runs with no idling at all.
        drain_next = 1'b1;
        random_start = text_bytes.size();
        while (text_bytes.size() - random_start < RANDOM_BYTES) begin
            case ($urandom_range(3, 0))
                0: odds = 0;
                1: odds = 3;
                default: odds = 8;
            endcase
            if (text_bytes.size() - random_start >= QUIET_FROM) odds = 0;
            if ($urandom_range(15, 0) == 0) add_byte(bst_pkg::CH_NUL, odds);
            else add_random_source(odds);
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        while (next_item < text_bytes.size() || expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_tokens.size() != 0) begin
            $display("%0t: %0d expected tokens never arrived", $time, expected_tokens.size());
            failures++;
        end
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ byte_stream_tokenizer.f @@
+incdir+rtl
rtl/bst_pkg.sv
rtl/byte_stream_tokenizer.sv
verif/byte_stream_tokenizer_tb.sv
